// File: sv/iou_bm_pkg.sv
// Package for the box overlap matcher: sizes, op codes, box record and sequencer states.
// Used by the top level and its checker; depends on nothing else.
`default_nettype none

package iou_bm_pkg;

  localparam int MAX_BOXES  = 16;
  localparam int COORD_BITS = 12;

  localparam int IDX_W   = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int EDGE_W  = COORD_BITS + 1;
  localparam int AREA_W  = 2 * EDGE_W;
  localparam int PROD_W  = 2 * AREA_W;
  localparam int BOX_W   = 4 * COORD_BITS;

  localparam int FIELD_W  = 12;
  localparam int SLOT_W   = 4;
  localparam int OP_W     = 2;
  localparam int THRESH_W = 16;

  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_MATCH_THRESHOLD = REG_IDX_W'(0);
  localparam logic [THRESH_W-1:0]  THRESH_RESET        = 16'd36045;
  localparam logic [AREA_W-1:0]    RATIO_ONE           = AREA_W'(65536);

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_INVAL = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
  } box_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_EDGE,
    S_MUL_I,
    S_MUL_U,
    S_MUL_A,
    S_MUL_B,
    S_CMP,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

// File: sv/iou_bm_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; it depends on no package.
`default_nettype none

module iou_bm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  input  wire logic                                    re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: sv/iou_box_matcher_unit.sv
// Top level of the box overlap matcher: table of tracked boxes, scan sequencer and
// shared multiplier. Depends on iou_bm_pkg and iou_bm_ram.
`default_nettype none

// A write or invalidate item passes through the done state into the output register once
// accepted. A query walks the table slot by slot through one shared multiplier that forms
// the intersection area, the union area and both cross products in turn; a valid slot
// whose union area is zero, as when both boxes are empty, skips the cross products.
// The input is stalled while an item is at work; a finished result waits in the output
// register, so the next item can be taken while it is still stalled downstream.
module iou_box_matcher_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,

  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [iou_bm_pkg::OP_W-1:0]       op_i,
  input  wire logic [iou_bm_pkg::SLOT_W-1:0]     slot_i,
  input  wire logic [iou_bm_pkg::FIELD_W-1:0]    box_x_i,
  input  wire logic [iou_bm_pkg::FIELD_W-1:0]    box_y_i,
  input  wire logic [iou_bm_pkg::FIELD_W-1:0]    box_w_i,
  input  wire logic [iou_bm_pkg::FIELD_W-1:0]    box_h_i,

  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic                                   found_o,
  output logic [iou_bm_pkg::SLOT_W-1:0]          match_slot_o,

  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [iou_bm_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [iou_bm_pkg::DATA_W-1:0]     pwdata,
  output logic      [iou_bm_pkg::DATA_W-1:0]     prdata,
  output logic                                   pready
);

  localparam int IW = iou_bm_pkg::IDX_W;
  localparam int EW = iou_bm_pkg::EDGE_W;
  localparam int AW = iou_bm_pkg::AREA_W;
  localparam int PW = iou_bm_pkg::PROD_W;
  localparam int CB = iou_bm_pkg::COORD_BITS;

  iou_bm_pkg::state_e state_q, state_d;

  logic [iou_bm_pkg::THRESH_W-1:0] thresh_q;
  logic [iou_bm_pkg::MAX_BOXES-1:0] slot_valid_q;
  logic [IW-1:0] scan_idx_q;
  logic          found_q;
  logic [IW-1:0] best_slot_q;
  logic [AW-1:0] best_i_q, best_u_q;
  logic [AW-1:0] area_i_q, area_u_q;
  logic [PW-1:0] cross_a_q, cross_b_q;
  logic [EW-1:0] iw_q, ih_q, uw_q, uh_q;
  iou_bm_pkg::box_t query_q;

  logic out_valid_q, out_found_q;
  logic [iou_bm_pkg::SLOT_W-1:0] out_slot_q;

  logic in_accept, cfg_write, slot_in_range, scan_last, out_load, ram_re;
  iou_bm_pkg::box_t in_box, tbl_box;
  logic [iou_bm_pkg::BOX_W-1:0] ram_rdata;
  logic [AW-1:0] mul_a, mul_b;
  logic [PW-1:0] mul_p;

  assign in_accept     = in_valid_i && !in_stall_o;
  assign slot_in_range = 32'(slot_i) < 32'(iou_bm_pkg::MAX_BOXES);
  assign scan_last     = scan_idx_q == IW'(iou_bm_pkg::MAX_BOXES - 1);
  assign out_load      = (state_q == iou_bm_pkg::S_DONE) && (!out_valid_q || !out_stall_i);

  assign in_box.x = CB'(box_x_i);
  assign in_box.y = CB'(box_y_i);
  assign in_box.w = CB'(box_w_i);
  assign in_box.h = CB'(box_h_i);
  assign tbl_box  = iou_bm_pkg::box_t'(ram_rdata);

  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_comb begin
    if (paddr[iou_bm_pkg::ADDR_W-1:2] == iou_bm_pkg::REG_MATCH_THRESHOLD) begin
      prdata = iou_bm_pkg::DATA_W'(thresh_q);
    end else begin
      prdata = '0;
    end
  end

  iou_bm_ram #(
    .WIDTH (iou_bm_pkg::BOX_W),
    .DEPTH (iou_bm_pkg::MAX_BOXES)
  ) u_box_table (
    .clk_i   (clk_i),
    .we_i    (in_accept && (op_i == iou_bm_pkg::OP_WRITE) && slot_in_range),
    .waddr_i (IW'(slot_i)),
    .wdata_i (in_box),
    .re_i    (ram_re),
    .raddr_i (scan_idx_q),
    .rdata_o (ram_rdata)
  );

  // Intersection and bounding-rectangle edges of the query against the table entry.
  logic [EW-1:0] qx, qy, qe, qf, tx, ty, te, tf;
  logic [EW-1:0] ix0, ix1, iy0, iy1, iw_d, ih_d, uw_d, uh_d;
  logic          q_empty, t_empty;

  always_comb begin
    qx = EW'(query_q.x);
    qy = EW'(query_q.y);
    tx = EW'(tbl_box.x);
    ty = EW'(tbl_box.y);
    qe = qx + EW'(query_q.w);
    qf = qy + EW'(query_q.h);
    te = tx + EW'(tbl_box.w);
    tf = ty + EW'(tbl_box.h);
    q_empty = (query_q.w == '0) || (query_q.h == '0);
    t_empty = (tbl_box.w == '0) || (tbl_box.h == '0);

    ix0 = (qx > tx) ? qx : tx;
    ix1 = (qe < te) ? qe : te;
    iy0 = (qy > ty) ? qy : ty;
    iy1 = (qf < tf) ? qf : tf;
    iw_d = (ix1 > ix0) ? (ix1 - ix0) : '0;
    ih_d = (iy1 > iy0) ? (iy1 - iy0) : '0;

    if (q_empty) begin
      uw_d = EW'(tbl_box.w);
      uh_d = EW'(tbl_box.h);
    end else if (t_empty) begin
      uw_d = EW'(query_q.w);
      uh_d = EW'(query_q.h);
    end else begin
      uw_d = ((qe > te) ? qe : te) - ((qx < tx) ? qx : tx);
      uh_d = ((qf > tf) ? qf : tf) - ((qy < ty) ? qy : ty);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      iou_bm_pkg::S_IDLE: begin
        if (in_accept) begin
          state_d = (op_i == iou_bm_pkg::OP_QUERY) ? iou_bm_pkg::S_SCAN : iou_bm_pkg::S_DONE;
        end
      end
      iou_bm_pkg::S_SCAN: begin
        if (slot_valid_q[scan_idx_q]) begin
          state_d = iou_bm_pkg::S_EDGE;
        end else if (scan_last) begin
          state_d = iou_bm_pkg::S_DONE;
        end
      end
      iou_bm_pkg::S_EDGE:  state_d = iou_bm_pkg::S_MUL_I;
      iou_bm_pkg::S_MUL_I: state_d = iou_bm_pkg::S_MUL_U;
      iou_bm_pkg::S_MUL_U: state_d = iou_bm_pkg::S_MUL_A;
      iou_bm_pkg::S_MUL_A: begin
        if (area_u_q == '0) begin
          state_d = scan_last ? iou_bm_pkg::S_DONE : iou_bm_pkg::S_SCAN;
        end else begin
          state_d = iou_bm_pkg::S_MUL_B;
        end
      end
      iou_bm_pkg::S_MUL_B: state_d = iou_bm_pkg::S_CMP;
      iou_bm_pkg::S_CMP: begin
        state_d = scan_last ? iou_bm_pkg::S_DONE : iou_bm_pkg::S_SCAN;
      end
      iou_bm_pkg::S_DONE: begin
        if (out_load) begin
          state_d = iou_bm_pkg::S_IDLE;
        end
      end
      default: state_d = iou_bm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = state_q != iou_bm_pkg::S_IDLE;
    ram_re     = state_q == iou_bm_pkg::S_SCAN;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state_q)
      iou_bm_pkg::S_MUL_I: begin
        mul_a = AW'(iw_q);
        mul_b = AW'(ih_q);
      end
      iou_bm_pkg::S_MUL_U: begin
        mul_a = AW'(uw_q);
        mul_b = AW'(uh_q);
      end
      iou_bm_pkg::S_MUL_A: begin
        mul_a = area_i_q;
        mul_b = best_u_q;
      end
      iou_bm_pkg::S_MUL_B: begin
        mul_a = best_i_q;
        mul_b = area_u_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = PW'(mul_a) * PW'(mul_b);
  end

  logic scan_step;
  assign scan_step = ((state_q == iou_bm_pkg::S_SCAN) && !slot_valid_q[scan_idx_q]) ||
                     ((state_q == iou_bm_pkg::S_MUL_A) && (area_u_q == '0)) ||
                     (state_q == iou_bm_pkg::S_CMP);

  logic better;
  assign better = (state_q == iou_bm_pkg::S_CMP) && (cross_a_q > cross_b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= iou_bm_pkg::S_IDLE;
      thresh_q     <= iou_bm_pkg::THRESH_RESET;
      slot_valid_q <= '0;
      scan_idx_q   <= '0;
      found_q      <= 1'b0;
      best_slot_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_write && (paddr[iou_bm_pkg::ADDR_W-1:2] == iou_bm_pkg::REG_MATCH_THRESHOLD)) begin
        thresh_q <= pwdata[iou_bm_pkg::THRESH_W-1:0];
      end
      if (in_accept && slot_in_range) begin
        if (op_i == iou_bm_pkg::OP_WRITE) begin
          slot_valid_q[IW'(slot_i)] <= 1'b1;
        end else if (op_i == iou_bm_pkg::OP_INVAL) begin
          slot_valid_q[IW'(slot_i)] <= 1'b0;
        end
      end
      if (in_accept) begin
        scan_idx_q  <= '0;
        found_q     <= 1'b0;
        best_slot_q <= '0;
      end else begin
        if (scan_step && !scan_last) begin
          scan_idx_q <= scan_idx_q + IW'(1);
        end
        if (better) begin
          found_q     <= 1'b1;
          best_slot_q <= scan_idx_q;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      query_q  <= in_box;
      best_i_q <= AW'(thresh_q);
      best_u_q <= iou_bm_pkg::RATIO_ONE;
    end
    if (state_q == iou_bm_pkg::S_EDGE) begin
      iw_q <= iw_d;
      ih_q <= ih_d;
      uw_q <= uw_d;
      uh_q <= uh_d;
    end
    if (state_q == iou_bm_pkg::S_MUL_I) begin
      area_i_q <= mul_p[AW-1:0];
    end
    if (state_q == iou_bm_pkg::S_MUL_U) begin
      area_u_q <= mul_p[AW-1:0];
    end
    if (state_q == iou_bm_pkg::S_MUL_A) begin
      cross_a_q <= mul_p;
    end
    if (state_q == iou_bm_pkg::S_MUL_B) begin
      cross_b_q <= mul_p;
    end
    if (better) begin
      best_i_q <= area_i_q;
      best_u_q <= area_u_q;
    end
    if (out_load) begin
      out_found_q <= found_q;
      out_slot_q  <= found_q ? iou_bm_pkg::SLOT_W'(best_slot_q) : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign found_o      = out_found_q;
  assign match_slot_o = out_slot_q;

endmodule

`default_nettype wire

// File: sv/iou_bm_checker.sv
// Port-level checker for the box overlap matcher, bound to the top level.
// Depends on iou_bm_pkg and iou_box_matcher_unit.
`default_nettype none

module iou_bm_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_stall_o,
  input wire logic [iou_bm_pkg::OP_W-1:0]    op_i,
  input wire logic                           out_valid_o,
  input wire logic                           out_stall_i,
  input wire logic                           found_o,
  input wire logic [iou_bm_pkg::SLOT_W-1:0]  match_slot_o,
  input wire logic                           pready
);

  // A result held back downstream keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(found_o) && $stable(match_slot_o))
    else $error("Stalled result changed.");

  // Without a match the reported slot is zero.
  a_no_match_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> match_slot_o == '0)
    else $error("Slot reported without a match.");

  // The block works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Item taken while another is at work.");

  // Only a query can report a match; a write or invalidate answers without one.
  a_update_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (op_i != iou_bm_pkg::OP_QUERY) && !out_valid_o
      |=> ##1 out_valid_o && !found_o)
    else $error("Table update produced a wrong result.");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("Register port not ready.");

endmodule

bind iou_box_matcher_unit iou_bm_checker u_iou_bm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .op_i         (op_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .found_o      (found_o),
  .match_slot_o (match_slot_o),
  .pready       (pready)
);

`default_nettype wire
